// ===== rtl/phrq_pkg.sv =====
// Shared constants, codes and control types for the peak-hold ring queue.
`default_nettype none

package phrq_pkg;

    // ring geometry; pointers run modulo twice the depth
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = ADDR_W + 1;

    localparam int PUSHES_PER_SEC = 1000;
    localparam int PUSH_CNT_W     = 10;
    localparam int COUNT_W        = 24;
    localparam int SPM_W          = 8;
    localparam int THR_W          = PUSH_CNT_W + SPM_W;

    localparam logic [SPM_W-1:0] SPM_RESET = 8'd48;

    // field widths
    localparam int LEN_W  = 14;
    localparam int DB_W   = 16;
    localparam int MUL_W  = 16;
    localparam int SEC_W  = 8;
    localparam int PEAK_W = 15;

    // slave tdata layout, lowest bit first
    localparam int LEN_LSB    = 0;
    localparam int IN_DB_LSB  = LEN_LSB + LEN_W;
    localparam int OUT_DB_LSB = IN_DB_LSB + DB_W;
    localparam int MUL_LSB    = OUT_DB_LSB + DB_W;
    localparam int SEC_LSB    = MUL_LSB + MUL_W;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 48;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_MS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 1'b1;

    // operation carried in tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic [MUL_W-1:0]  mul;
        logic [PEAK_W-1:0] out_db;
        logic [PEAK_W-1:0] in_db;
    } ring_word_t;

    typedef struct packed {
        logic load;        // latch the input word
        logic fold;        // fold levels into held maxima, add length
        logic push_eval;   // compare count with threshold, push on hit
        logic rd_issue;    // pop one slot, read the ring
        logic rd_acc;      // fold the read entry into the section maxima
        logic out_load;    // hand the section maxima to the output register
        logic clr_write;   // clearing pass after reset
    } ctrl_cmd_t;

    typedef struct packed {
        logic enable;
        logic sec_zero;
        logic clr_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/phrq_dpath.sv =====
// Datapath: registers, ring memory, pointer arithmetic and peak folding.
`default_nettype none

module phrq_dpath (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_valid,
    input  wire  [phrq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [phrq_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire  [phrq_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire  phrq_pkg::ctrl_cmd_t         cmd,
    output phrq_pkg::dp_status_t              status,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [phrq_pkg::M_DATA_W-1:0]     m_tdata
);
    import phrq_pkg::*;

    ring_word_t ring_mem [DEPTH];

    logic [SPM_W-1:0]      spm_reg, spm_next;
    logic                  enable_reg, enable_next;
    logic [PTR_W-1:0]      wptr_reg, wptr_next;
    logic [PTR_W-1:0]      rptr_reg, rptr_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [PUSH_CNT_W-1:0] pushed_reg, pushed_next;
    logic [PEAK_W-1:0]     held_in_reg, held_in_next;
    logic [PEAK_W-1:0]     held_out_reg, held_out_next;
    logic [MUL_W-1:0]      held_mul_reg, held_mul_next;
    logic [SEC_W-1:0]      sec_reg, sec_next;
    logic [ADDR_W-1:0]     clr_reg, clr_next;
    logic                  m_valid_reg, m_valid_next;

    logic [LEN_W-1:0]      len_reg;
    logic [DB_W-1:0]       idb_reg;
    logic [DB_W-1:0]       odb_reg;
    logic [MUL_W-1:0]      mul_reg;
    logic [THR_W-1:0]      thr_reg;
    ring_word_t            acc_reg, acc_next;
    ring_word_t            rdata_reg;
    ring_word_t            m_data_reg;

    logic [PTR_W-1:0]      fill;
    logic [PTR_W-1:0]      rptr_eff;
    logic [COUNT_W:0]      count_sum;
    logic [SPM_W-1:0]      spm_eff;
    logic [PUSH_CNT_W-1:0] pushed_inc;
    logic                  push_hit;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    ring_word_t            mem_wdata;

    always_comb
    begin
        fill       = wptr_reg - rptr_reg;
        rptr_eff   = (fill == '0) ? wptr_reg - PTR_W'(1) : rptr_reg;
        count_sum  = {1'b0, count_reg} + (COUNT_W+1)'(len_reg);
        spm_eff    = (spm_reg == '0) ? SPM_W'(1) : spm_reg;
        pushed_inc = pushed_reg + PUSH_CNT_W'(1);
        push_hit   = {{(COUNT_W-THR_W){1'b0}}, thr_reg} <= count_reg;

        spm_next      = spm_reg;
        enable_next   = enable_reg;
        wptr_next     = wptr_reg;
        rptr_next     = rptr_reg;
        count_next    = count_reg;
        pushed_next   = pushed_reg;
        held_in_next  = held_in_reg;
        held_out_next = held_out_reg;
        held_mul_next = held_mul_reg;
        sec_next      = sec_reg;
        clr_next      = clr_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg;
        mem_we        = 1'b0;
        mem_waddr     = wptr_reg[ADDR_W-1:0];
        mem_wdata     = '{mul: held_mul_reg, out_db: held_out_reg, in_db: held_in_reg};

        if (cmd.clr_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
            clr_next  = clr_reg + ADDR_W'(1);
        end

        if (cmd.load)
        begin
            sec_next = s_tdata[SEC_LSB +: SEC_W];
            acc_next = '0;
        end

        if (cmd.fold)
        begin
            if ($signed(idb_reg) > $signed({1'b0, held_in_reg}))
                held_in_next = idb_reg[PEAK_W-1:0];
            if ($signed(odb_reg) > $signed({1'b0, held_out_reg}))
                held_out_next = odb_reg[PEAK_W-1:0];
            if (mul_reg > held_mul_reg)
                held_mul_next = mul_reg;
            // saturate the sample count
            count_next = count_sum[COUNT_W] ? '1 : count_sum[COUNT_W-1:0];
        end

        if (cmd.push_eval && push_hit)
        begin
            mem_we = 1'b1;
            // ring full: drop the older half
            if (fill >= PTR_W'(DEPTH))
                rptr_next = wptr_reg - PTR_W'(DEPTH / 2);
            wptr_next     = wptr_reg + PTR_W'(1);
            held_in_next  = '0;
            held_out_next = '0;
            held_mul_next = '0;
            if (pushed_inc == PUSH_CNT_W'(PUSHES_PER_SEC))
            begin
                pushed_next = '0;
                count_next  = '0;
            end
            else
            begin
                pushed_next = pushed_inc;
            end
        end

        if (cmd.rd_issue)
            rptr_next = rptr_eff + PTR_W'(1);

        if (cmd.rd_acc)
        begin
            if (rdata_reg.in_db > acc_reg.in_db)
                acc_next.in_db = rdata_reg.in_db;
            if (rdata_reg.out_db > acc_reg.out_db)
                acc_next.out_db = rdata_reg.out_db;
            if (rdata_reg.mul > acc_reg.mul)
                acc_next.mul = rdata_reg.mul;
            sec_next = sec_reg - SEC_W'(1);
        end

        if (cmd.out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;

        if (cfg_valid)
        begin
            priority if (cfg_index == CFG_SAMPLES_PER_MS)
            begin
                spm_next = cfg_data;
            end
            else if (cfg_index == CFG_ENABLE)
            begin
                enable_next = cfg_data[0];
                if (cfg_data[0])
                begin
                    wptr_next   = '0;
                    rptr_next   = '0;
                    count_next  = '0;
                    pushed_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spm_reg      <= SPM_RESET;
            enable_reg   <= 1'b0;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            count_reg    <= '0;
            pushed_reg   <= '0;
            held_in_reg  <= '0;
            held_out_reg <= '0;
            held_mul_reg <= '0;
            sec_reg      <= '0;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            spm_reg      <= spm_next;
            enable_reg   <= enable_next;
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            count_reg    <= count_next;
            pushed_reg   <= pushed_next;
            held_in_reg  <= held_in_next;
            held_out_reg <= held_out_next;
            held_mul_reg <= held_mul_next;
            sec_reg      <= sec_next;
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg <= s_tdata[LEN_LSB +: LEN_W];
            idb_reg <= s_tdata[IN_DB_LSB +: DB_W];
            odb_reg <= s_tdata[OUT_DB_LSB +: DB_W];
            mul_reg <= s_tdata[MUL_LSB +: MUL_W];
        end
        if (cmd.fold)
            thr_reg <= THR_W'(pushed_inc) * THR_W'(spm_eff);
        acc_reg <= acc_next;
        if (cmd.out_load)
            m_data_reg <= acc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_waddr] <= mem_wdata;
        if (cmd.rd_issue)
            rdata_reg <= ring_mem[rptr_eff[ADDR_W-1:0]];
    end

    always_comb
    begin
        status.enable   = enable_reg;
        status.sec_zero = (sec_reg == '0);
        status.clr_last = (clr_reg == ADDR_W'(DEPTH - 1));
        status.out_free = !m_valid_reg || m_tready;
        m_tvalid        = m_valid_reg;
        m_tdata         = {{(M_DATA_W - $bits(ring_word_t)){1'b0}}, m_data_reg};
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= PTR_W'(DEPTH))
        else $error("ring fill beyond depth");

    a_pushed_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pushed_reg < PUSH_CNT_W'(PUSHES_PER_SEC))
        else $error("push count beyond one second");

    a_push_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_eval && push_hit |=> held_in_reg == '0 && held_out_reg == '0
            && held_mul_reg == '0)
        else $error("held maxima kept after push");

    a_push_advances: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_eval && push_hit && !cfg_valid |=> wptr_reg == $past(wptr_reg) + PTR_W'(1))
        else $error("write pointer did not advance on push");

endmodule

`default_nettype wire

// ===== rtl/phrq_ctrl.sv =====
// Controller: sequences clearing, push and read work and drives datapath commands.
`default_nettype none

module phrq_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_tvalid,
    input  wire                   s_tuser,
    output logic                  s_tready,
    output phrq_pkg::ctrl_cmd_t   cmd,
    input  wire phrq_pkg::dp_status_t status
);
    import phrq_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FOLD,
        ST_EVAL,
        ST_RD_CHECK,
        ST_RD_ISSUE,
        ST_RD_ACC,
        ST_RD_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    always_comb
    begin
        s_tready   = (state_reg == ST_IDLE);
        accept     = s_tready && s_tvalid;
        cmd        = '0;
        state_next = state_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = (s_tuser == OP_READ) ? ST_RD_CHECK : ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                // drop pushes while disabled
                cmd.fold   = status.enable;
                state_next = status.enable ? ST_EVAL : ST_IDLE;
            end
            ST_EVAL:
            begin
                cmd.push_eval = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_RD_CHECK:
            begin
                state_next = status.sec_zero ? ST_RD_DONE : ST_RD_ISSUE;
            end
            ST_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_ACC;
            end
            ST_RD_ACC:
            begin
                cmd.rd_acc = 1'b1;
                state_next = ST_RD_CHECK;
            end
            ST_RD_DONE:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !cmd.load && !cmd.rd_issue && !cmd.push_eval)
        else $error("work started during clearing pass");

    a_read_ends_in_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == ST_IDLE)
        else $error("output load did not return to idle");

    a_issue_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> cmd.rd_acc)
        else $error("ring read not folded");

endmodule

`default_nettype wire

// ===== rtl/peak_hold_ms_ring_queue_unit.sv =====
// Peak-hold millisecond decimator feeding a ring of peaks: top level.
// Push word: latch, fold, compare and write before ready returns; dropped after the latch while disabled.
// Read word of n entries: one ring read and fold per entry, then a wait for a free output register.
// Results sit in an output register, so the next word is taken while one waits.
// After rst_n the ring is swept to zero, one entry a cycle, before the first word is taken;
// configuration writes are taken throughout.
`default_nettype none

module peak_hold_ms_ring_queue_unit (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [phrq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [phrq_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // buffer_length[13:0], in_db[29:14], out_db[45:30], gain_mul[61:46],
    // section_ms[69:62], zero [71:70]
    input  wire  [phrq_pkg::S_DATA_W-1:0]   s_tdata,
    // op[0]
    input  wire                             s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // peak_in_db[14:0], peak_out_db[29:15], peak_mul[45:30], zero [47:46]
    output logic [phrq_pkg::M_DATA_W-1:0]   m_tdata
);
    import phrq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    phrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    phrq_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking stream testbench for the peak-hold millisecond ring queue.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import phrq_pkg::*;

    localparam int QUIET_LIMIT = 10000;

    typedef struct packed {
        logic             op;
        logic [LEN_W-1:0] len;
        logic [DB_W-1:0]  in_db;
        logic [DB_W-1:0]  out_db;
        logic [MUL_W-1:0] mul;
        logic [SEC_W-1:0] sec;
    } item_t;

    typedef struct packed {
        logic [PEAK_W-1:0] in_db;
        logic [PEAK_W-1:0] out_db;
        logic [MUL_W-1:0]  mul;
    } peak_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    peak_hold_ms_ring_queue_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    // stimulus and expectations
    item_t item_q[$];
    peak_t peaks_due[$];
    item_t cur_word;
    logic  s_took = 1'b0;
    int    words_open = 0;
    int    errors = 0;
    int    quiet = 0;
    int    src_idle_pct = 0;
    int    sink_stall_pct = 0;

    // predictor state
    logic [15:0]      pk_in [DEPTH];
    logic [15:0]      pk_out [DEPTH];
    logic [15:0]      pk_mul [DEPTH];
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    logic [15:0]      hold_in;
    logic [15:0]      hold_out;
    logic [15:0]      hold_mul;
    int unsigned      samp_acc;
    int unsigned      ms_pushed;
    logic [7:0]       spm_reg;
    logic             en_reg;

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        if (idx == CFG_SAMPLES_PER_MS)
            spm_reg = val;
        else if (idx == CFG_ENABLE)
        begin
            en_reg = val[0];
            if (en_reg)
            begin
                wr_ptr = '0;
                rd_ptr = '0;
                samp_acc = 0;
                ms_pushed = 0;
            end
        end
    endtask

    task automatic track_peaks(input item_t w);
        int unsigned      spm_eff;
        int               lvl_in;
        int               lvl_out;
        logic [PTR_W-1:0] fill;
        logic [15:0]      pi;
        logic [15:0]      po;
        logic [15:0]      pm;
        peak_t            due;
        if (w.op == OP_PUSH)
        begin
            if (en_reg)
            begin
                spm_eff = (spm_reg == 0) ? 1 : spm_reg;
                lvl_in = $signed(w.in_db);
                lvl_out = $signed(w.out_db);
                if (lvl_in > int'(hold_in))
                    hold_in = w.in_db;
                if (lvl_out > int'(hold_out))
                    hold_out = w.out_db;
                if (w.mul > hold_mul)
                    hold_mul = w.mul;
                samp_acc = samp_acc + w.len;
                if (samp_acc > 32'hFF_FFFF)
                    samp_acc = 32'hFF_FFFF;
                if (samp_acc / spm_eff > ms_pushed)
                begin
                    // ring full: drop the older half before writing
                    fill = wr_ptr - rd_ptr;
                    if (fill >= DEPTH)
                        rd_ptr = wr_ptr - PTR_W'(DEPTH / 2);
                    pk_in[wr_ptr[ADDR_W-1:0]] = hold_in;
                    pk_out[wr_ptr[ADDR_W-1:0]] = hold_out;
                    pk_mul[wr_ptr[ADDR_W-1:0]] = hold_mul;
                    wr_ptr = wr_ptr + 1'b1;
                    ms_pushed = ms_pushed + 1;
                    hold_in = '0;
                    hold_out = '0;
                    hold_mul = '0;
                    if (ms_pushed == PUSHES_PER_SEC)
                    begin
                        samp_acc = 0;
                        ms_pushed = 0;
                    end
                end
            end
        end
        else
        begin
            pi = '0;
            po = '0;
            pm = '0;
            for (int n = 0; n < w.sec; n++)
            begin
                // underrun: step back onto the newest entry
                fill = wr_ptr - rd_ptr;
                if (fill == 0)
                    rd_ptr = wr_ptr - 1'b1;
                if (pk_in[rd_ptr[ADDR_W-1:0]] > pi)
                    pi = pk_in[rd_ptr[ADDR_W-1:0]];
                if (pk_out[rd_ptr[ADDR_W-1:0]] > po)
                    po = pk_out[rd_ptr[ADDR_W-1:0]];
                if (pk_mul[rd_ptr[ADDR_W-1:0]] > pm)
                    pm = pk_mul[rd_ptr[ADDR_W-1:0]];
                rd_ptr = rd_ptr + 1'b1;
            end
            due.in_db = pi[PEAK_W-1:0];
            due.out_db = po[PEAK_W-1:0];
            due.mul = pm;
            peaks_due.push_back(due);
        end
    endtask

    function automatic logic [15:0] rand_level();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] rand_len(input logic [7:0] spm);
        int unsigned top;
        top = (spm == 0) ? 3 : 3 * spm;
        case ($urandom_range(9))
            0: return '0;
            1: return 14'd8192;
            2, 3, 4: return LEN_W'($urandom_range(0, 8192));
            default: return LEN_W'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic [SEC_W-1:0] rand_section(input bit deep);
        if (!deep)
            return SEC_W'($urandom_range(0, 3));
        case ($urandom_range(19))
            0: return 8'd255;
            1, 2: return SEC_W'($urandom_range(0, 255));
            default: return SEC_W'($urandom_range(0, 8));
        endcase
    endfunction

    task automatic queue_push(input logic [LEN_W-1:0] len, input logic [15:0] in_db,
                              input logic [15:0] out_db, input logic [15:0] mul);
        item_t w;
        w.op = OP_PUSH;
        w.len = len;
        w.in_db = in_db;
        w.out_db = out_db;
        w.mul = mul;
        w.sec = SEC_W'($urandom);
        item_q.push_back(w);
        words_open++;
    endtask

    task automatic queue_read(input logic [SEC_W-1:0] sec);
        item_t w;
        w.op = OP_READ;
        w.len = LEN_W'($urandom);
        w.in_db = 16'($urandom);
        w.out_db = 16'($urandom);
        w.mul = 16'($urandom);
        w.sec = sec;
        item_q.push_back(w);
        words_open++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // hold until every word is taken and every result is back, then let pushes drain
    task automatic settle();
        do
            @(negedge clk);
        while (words_open != 0 || peaks_due.size() != 0);
        repeat (20) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] spm, input logic en, input int count,
                             input int push_pct, input int idle, input int stall);
        settle();
        src_idle_pct = idle;
        sink_stall_pct = stall;
        write_reg(CFG_SAMPLES_PER_MS, spm);
        write_reg(CFG_ENABLE, {7'd0, en});
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < push_pct)
                queue_push(rand_len(spm), rand_level(), rand_level(), rand_level());
            else
                queue_read(rand_section(count < 500));
        end
    endtask

    // driver: present the next word at the falling edge
    always @(negedge clk)
    begin
        item_t w;
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (rst_n && (!s_tvalid || s_took))
        begin
            if (item_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                w = item_q.pop_front();
                cur_word <= w;
                s_tdata <= {2'b00, w.sec, w.mul, w.out_db, w.in_db, w.len};
                s_tuser <= w.op;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor, predictor update and watchdog at the rising edge
    always @(posedge clk)
    begin
        peak_t due;
        s_took <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (peaks_due.size() == 0)
                begin
                    $error("result word %h with no read outstanding", m_tdata);
                    errors++;
                end
                else
                begin
                    due = peaks_due.pop_front();
                    if (m_tdata[14:0] !== due.in_db)
                    begin
                        $error("peak_in_db: expected %0d, got %0d", due.in_db, m_tdata[14:0]);
                        errors++;
                    end
                    if (m_tdata[29:15] !== due.out_db)
                    begin
                        $error("peak_out_db: expected %0d, got %0d", due.out_db, m_tdata[29:15]);
                        errors++;
                    end
                    if (m_tdata[45:30] !== due.mul)
                    begin
                        $error("peak_mul: expected %0d, got %0d", due.mul, m_tdata[45:30]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                track_peaks(cur_word);
                words_open--;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            pk_in[i] = '0;
            pk_out[i] = '0;
            pk_mul[i] = '0;
        end
        wr_ptr = '0;
        rd_ptr = '0;
        hold_in = '0;
        hold_out = '0;
        hold_mul = '0;
        samp_acc = 0;
        ms_pushed = 0;
        spm_reg = SPM_RESET;
        en_reg = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // disabled after reset: underrun on an untouched ring, ignored push, empty section
        queue_read(8'd1);
        queue_push(14'd8192, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        queue_read(8'd0);
        settle();

        // zero samples per ms acts as one
        write_reg(CFG_SAMPLES_PER_MS, 8'd0);
        write_reg(CFG_ENABLE, 8'd1);
        queue_push(14'd0, 16'h7FFF, 16'h8000, 16'hFFFF);
        queue_push(14'd1, 16'hFFFF, 16'h7FFF, 16'h0000);
        queue_push(14'd8192, 16'h0100, 16'h0000, 16'h0001);
        queue_read(8'd1);
        queue_read(8'd2);
        queue_read(8'd0);
        queue_push(14'd1, 16'h8000, 16'h8000, 16'h0000);
        settle();

        // enable again while enabled: pointers restart, read underruns
        write_reg(CFG_ENABLE, 8'd1);
        queue_read(8'd1);
        settle();

        write_reg(CFG_SAMPLES_PER_MS, 8'd192);
        queue_push(14'd100, 16'h1234, 16'h4321, 16'h8000);
        queue_push(14'd100, 16'h0FFF, 16'hF000, 16'h7FFF);
        queue_push(14'd8192, 16'h0001, 16'h0002, 16'h0003);
        queue_read(8'd255);
        settle();

        // read carried out while disabled
        write_reg(CFG_ENABLE, 8'd0);
        queue_push(14'd8192, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        queue_read(8'd3);

        // push-heavy stretch fills the ring and wraps the second
        run_phase(8'd1, 1'b1, 1200, 98, 0, 0);
        run_phase(8'd192, 1'b1, 70, 60, 68, 0);
        run_phase(8'($urandom_range(2, 191)), 1'b1, 70, 50, 0, 68);
        run_phase(8'd0, 1'b0, 30, 50, 25, 25);
        run_phase(8'd48, 1'b1, 70, 60, 25, 25);

        settle();
        repeat (800) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/phrq_pkg.sv
rtl/phrq_dpath.sv
rtl/phrq_ctrl.sv
rtl/peak_hold_ms_ring_queue_unit.sv
tb/sv/testbench.sv
